@@ rtl/core/itoa_pkg.sv @@
`default_nettype none
package itoa_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int CHAR_WIDTH      = 7;

	typedef enum logic [1:0] {
		KIND_SDEC = 2'd0,
		KIND_UDEC = 2'd1,
		KIND_OCT  = 2'd2,
		KIND_HEX  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_WIDTH-1:0] CH_ALPHA = 7'h37;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 7'h2D;
	localparam logic [3:0]            DEC_TEN  = 4'd10;

	function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_WIDTH-1:0] base;
		base = (d >= DEC_TEN) ? CH_ALPHA : CH_ZERO;
		return base + {3'b000, d};
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/itoa_num_if.sv @@
`default_nettype none
interface itoa_num_if
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             kind;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/itoa_chr_if.sv @@
`default_nettype none
interface itoa_chr_if
	import itoa_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CHAR_WIDTH-1:0] ascii_char;
	logic                  is_last;

	modport source (output valid, output ascii_char, output is_last, input ready);
	modport sink   (input valid, input ascii_char, input is_last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/integer_to_ascii_digits_unit.sv @@
`default_nettype none
// channel  dir  payload                 transaction
// num      in   kind[1:0], value[W-1:0] one number to print
// chr      out  ascii_char[6:0], is_last one character, most significant first
//
// A number goes through the bit-serial radix converter (one input bit per cycle through
// the digit lanes), then an optional sign character, then leading zeros are dropped,
// then the characters go out one by one while chr is ready.
// A new number is taken only when the previous one has handed its last character to
// the output register. arst_n clears control state; chr stalls hold the sign and digit states.
module integer_to_ascii_digits_unit
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	itoa_num_if.sink    num,
	itoa_chr_if.source  chr
);
	localparam int NDEC = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int NOCT = (VALUE_WIDTH + 2) / 3;
	localparam int NDIG = (NDEC > NOCT) ? NDEC : NOCT;
	localparam int CW   = $clog2(VALUE_WIDTH + 1);
	localparam int RW   = $clog2(NDIG + 1);

	state_t                 state_q, state_d;
	kind_t                  kind_q;
	logic                   neg_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]          cnt_q;
	logic [RW-1:0]          rem_q;
	logic [3:0]             dig_q [NDIG];
	logic [3:0]             corr  [NDIG];
	logic [3:0]             nxt   [NDIG];
	logic [NDIG-1:0]        cout;
	logic                   out_valid_q;
	logic [CHAR_WIDTH-1:0]  out_char_q;
	logic                   out_last_q;

	logic                   accept;
	logic                   out_free;
	logic                   load_sign, load_dig, shift_up, conv_step;
	logic                   is_dec, is_oct;
	logic [VALUE_WIDTH-1:0] mag;

	assign accept   = num.valid && num.ready;
	assign out_free = !out_valid_q || chr.ready;
	assign is_dec   = (kind_q == KIND_SDEC) || (kind_q == KIND_UDEC);
	assign is_oct   = (kind_q == KIND_OCT);

	assign num.ready      = (state_q == ST_IDLE);
	assign chr.valid      = out_valid_q;
	assign chr.ascii_char = out_char_q;
	assign chr.is_last    = out_last_q;

	always_comb begin
		mag = num.value;
		if ((kind_t'(num.kind) == KIND_SDEC) && num.value[VALUE_WIDTH-1]) begin
			mag = (~num.value) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
		end
	end

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			corr[i] = dig_q[i];
			if (is_dec && (dig_q[i] >= 4'd5)) begin
				corr[i] = dig_q[i] + 4'd3;
			end
			cout[i] = is_oct ? corr[i][2] : corr[i][3];
		end
		for (int i = 0; i < NDIG; i++) begin
			if (i == 0) begin
				nxt[i] = is_oct ? {1'b0, corr[i][1:0], val_q[VALUE_WIDTH-1]}
				                : {corr[i][2:0], val_q[VALUE_WIDTH-1]};
			end else begin
				nxt[i] = is_oct ? {1'b0, corr[i][1:0], cout[i-1]}
				                : {corr[i][2:0], cout[i-1]};
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		load_sign = 1'b0;
		load_dig  = 1'b0;
		shift_up  = 1'b0;
		conv_step = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				conv_step = 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = neg_q ? ST_SIGN : ST_SKIP;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					load_sign = 1'b1;
					state_d   = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if ((dig_q[NDIG-1] == 4'd0) && (rem_q != RW'(1))) begin
					shift_up = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load_dig = 1'b1;
					shift_up = 1'b1;
					if (rem_q == RW'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_sign || load_dig) begin
				out_valid_q <= 1'b1;
			end else if (chr.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(num.kind);
			neg_q  <= (kind_t'(num.kind) == KIND_SDEC) && num.value[VALUE_WIDTH-1];
			val_q  <= mag;
			cnt_q  <= CW'(VALUE_WIDTH);
			rem_q  <= RW'(NDIG);
			for (int i = 0; i < NDIG; i++) begin
				dig_q[i] <= 4'd0;
			end
		end else if (conv_step) begin
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q - CW'(1);
			for (int i = 0; i < NDIG; i++) begin
				dig_q[i] <= nxt[i];
			end
		end else if (shift_up) begin
			rem_q <= rem_q - RW'(1);
			for (int i = NDIG - 1; i > 0; i--) begin
				dig_q[i] <= dig_q[i-1];
			end
			dig_q[0] <= 4'd0;
		end
		if (load_sign) begin
			out_char_q <= CH_MINUS;
			out_last_q <= 1'b0;
		end else if (load_dig) begin
			out_char_q <= digit_char(dig_q[NDIG-1]);
			out_last_q <= (rem_q == RW'(1));
		end
	end

`ifndef ASSERT_OFF
	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV))
		else $error("accepted number did not start conversion");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_char_q == CH_MINUS)) |-> !out_last_q)
		else $error("sign character flagged as last");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SKIP) || (state_q == ST_EMIT)) |-> (rem_q != RW'(0)))
		else $error("digit count exhausted during emission");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_dig && (rem_q == RW'(1))) |=> (state_q == ST_IDLE))
		else $error("block busy after last character");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
module testbench;
	import itoa_pkg::*;

	localparam int VW          = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_LEN    = 400;
	localparam int SETTLE      = 60;

	localparam logic [6:0] CHR_ZERO  = 7'h30;
	localparam logic [6:0] CHR_ALPHA = 7'h37;
	localparam logic [6:0] CHR_DASH  = 7'h2D;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} glyph_t;

	typedef struct {
		kind_t          kind;
		logic [VW-1:0]  value;
	} num_item_t;

	logic clk;
	logic arst_n;

	itoa_num_if #(.VALUE_WIDTH(VW)) num_bus ();
	itoa_chr_if                     chr_bus ();

	integer_to_ascii_digits_unit #(.VALUE_WIDTH(VW)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_bus),
		.chr    (chr_bus)
	);

	num_item_t   pending_nums[$];
	glyph_t      expected_glyphs[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        num_fired;
	logic        hold_req;
	logic        hold_done;
	int          hold_count;
	int          err_count;
	int          chars_checked;
	int          nums_by_kind[4];
	int          cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void predict_glyphs(input kind_t kind, input logic [VW-1:0] value);
		logic [VW-1:0] mag;
		logic [VW-1:0] radix;
		logic [VW-1:0] d;
		logic [6:0]    rev[$];
		bit            neg;
		int            i;
		mag = value;
		neg = 1'b0;
		case (kind)
			KIND_SDEC: begin
				radix = 10;
				if (value[VW-1]) begin
					neg = 1'b1;
					mag = -value;
				end
			end
			KIND_UDEC: radix = 10;
			KIND_OCT:  radix = 8;
			default:   radix = 16;
		endcase
		do begin
			d = mag % radix;
			rev.push_back((d >= 10) ? CHR_ALPHA + d[6:0] : CHR_ZERO + d[6:0]);
			mag = mag / radix;
		end while (mag != 0);
		if (neg)
			expected_glyphs.push_back(glyph_t'{CHR_DASH, 1'b0});
		for (i = rev.size() - 1; i >= 0; i--)
			expected_glyphs.push_back(glyph_t'{rev[i], (i == 0)});
	endfunction

	function automatic logic [VW-1:0] pick_value();
		logic [VW-1:0] v;
		case ($urandom_range(4))
			0: v = $urandom_range(0, 99);
			1: v = 32'h8000_0000 + $urandom_range(0, 4) - 2;
			2: v = 32'h1 << $urandom_range(VW - 1);
			3: v = ~(32'h1 << $urandom_range(VW - 1));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic add_num(input kind_t kind, input logic [VW-1:0] value);
		num_item_t it;
		it.kind  = kind;
		it.value = value;
		pending_nums.push_back(it);
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_nums.size() != 0 || num_bus.valid || expected_glyphs.size() != 0);
	endtask

	task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
			input int count, input bit hold);
		int n;
		@(posedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		if (hold)
			hold_req = 1'b1;
		for (n = 0; n < count; n++)
			add_num(kind_t'($urandom_range(3)), pick_value());
		drain();
	endtask

	// drive the number channel
	always @(negedge clk) begin
		num_item_t nxt;
		if (!arst_n) begin
			num_bus.valid <= 1'b0;
		end else if (!num_bus.valid || num_fired) begin
			if (pending_nums.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pending_nums.pop_front();
				num_bus.valid <= 1'b1;
				num_bus.kind  <= nxt.kind;
				num_bus.value <= nxt.value;
			end else begin
				num_bus.valid <= 1'b0;
			end
		end
	end

	// record accepted numbers and predict their text
	always @(posedge clk) begin
		num_fired <= arst_n && num_bus.valid && num_bus.ready;
		if (arst_n && num_bus.valid && num_bus.ready) begin
			predict_glyphs(kind_t'(num_bus.kind), num_bus.value);
			nums_by_kind[num_bus.kind]++;
		end
	end

	// long output hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			if (hold_count == HOLD_LEN)
				hold_done <= 1'b1;
			else
				hold_count <= hold_count + 1;
		end
	end

	always @(negedge clk) begin
		chr_bus.ready <= !(hold_req && !hold_done) && ($urandom_range(99) >= recv_stall_pct);
	end

	// check each character against the oldest prediction
	always @(posedge clk) begin
		glyph_t want;
		if (arst_n && chr_bus.valid && chr_bus.ready) begin
			if (expected_glyphs.size() == 0) begin
				$error("unexpected character: ascii_char=%h is_last=%b",
					chr_bus.ascii_char, chr_bus.is_last);
				err_count++;
			end else begin
				want = expected_glyphs.pop_front();
				chars_checked++;
				if (chr_bus.ascii_char !== want.ch) begin
					$error("ascii_char mismatch: expected %h, actual %h",
						want.ch, chr_bus.ascii_char);
					err_count++;
				end
				if (chr_bus.is_last !== want.last) begin
					$error("is_last mismatch: expected %b, actual %b",
						want.last, chr_bus.is_last);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		num_bus.valid  = 1'b0;
		num_bus.kind   = KIND_SDEC;
		num_bus.value  = '0;
		chr_bus.ready  = 1'b0;
		num_fired      = 1'b0;
		hold_req       = 1'b0;
		hold_done      = 1'b0;
		hold_count     = 0;
		err_count      = 0;
		chars_checked  = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		nums_by_kind   = '{default: 0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_num(KIND_SDEC, 32'h0000_0000);
		add_num(KIND_UDEC, 32'h0000_0000);
		add_num(KIND_OCT,  32'h0000_0000);
		add_num(KIND_HEX,  32'h0000_0000);
		add_num(KIND_SDEC, 32'h8000_0000);
		add_num(KIND_SDEC, 32'hFFFF_FFFF);
		add_num(KIND_SDEC, 32'h7FFF_FFFF);
		add_num(KIND_SDEC, 32'h0000_0009);
		add_num(KIND_SDEC, -32'sd1234567890);
		add_num(KIND_UDEC, 32'hFFFF_FFFF);
		add_num(KIND_UDEC, 32'h8000_0000);
		add_num(KIND_UDEC, 32'd10);
		add_num(KIND_UDEC, 32'd1000000000);
		add_num(KIND_OCT,  32'hFFFF_FFFF);
		add_num(KIND_OCT,  32'd7);
		add_num(KIND_OCT,  32'd8);
		add_num(KIND_HEX,  32'hFFFF_FFFF);
		add_num(KIND_HEX,  32'hABCD_EF01);
		add_num(KIND_HEX,  32'd15);
		add_num(KIND_HEX,  32'd16);
		add_num(KIND_HEX,  32'h2345_6789);
		drain();

		run_phase(0, 0, 25, 1'b0);
		run_phase(76, 0, 25, 1'b0);
		run_phase(0, 76, 25, 1'b0);
		run_phase(33, 33, 25, 1'b0);
		run_phase(0, 0, 15, 1'b1);

		repeat (SETTLE) @(posedge clk);
		if (expected_glyphs.size() != 0) begin
			$error("%0d predicted characters never arrived", expected_glyphs.size());
			err_count++;
		end
		$display("numbers taken: %0d signed dec, %0d unsigned dec, %0d octal, %0d hex",
			nums_by_kind[0], nums_by_kind[1], nums_by_kind[2], nums_by_kind[3]);
		$display("characters checked: %0d, across idle/stall mixes and a %0d-cycle output hold",
			chars_checked, HOLD_LEN);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
